### design/y2abgr_pkg.sv
// ----------------------------------------------------------------------------
// y2abgr_pkg
// Constants and per-pixel arithmetic for the YUYV to ABGR converter
// (BT.601 integer coefficients).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package y2abgr_pkg;

  localparam int unsigned SumW   = 21;  // holds every channel sum, signed
  localparam int unsigned ShiftW = 10;

  localparam logic signed [SumW-1:0] CoefY    = 21'sd1192;
  localparam logic signed [SumW-1:0] CoefRv   = 21'sd1634;
  localparam logic signed [SumW-1:0] CoefGv   = 21'sd833;
  localparam logic signed [SumW-1:0] CoefGu   = 21'sd400;
  localparam logic signed [SumW-1:0] CoefBu   = 21'sd2066;
  localparam logic signed [9:0]      LumaOffs = 10'sd16;
  localparam logic signed [8:0]      ChrOffs  = 9'sd128;
  localparam logic [7:0]             ChanMax  = 8'hFF;
  localparam logic [7:0]             AlphaVal = 8'hFF;

  typedef logic signed [SumW-1:0] sum_t;

  function automatic logic [7:0] chan_clamp(input sum_t s);
    sum_t q;
    q = s >>> ShiftW;
    if (s < 0) begin
      return 8'h00;
    end else if (q > sum_t'(ChanMax)) begin
      return ChanMax;
    end else begin
      return q[7:0];
    end
  endfunction

  // chroma offsets already removed
  function automatic logic [31:0] make_pixel(input logic [7:0]        y,
                                             input logic signed [8:0] u,
                                             input logic signed [8:0] v);
    logic signed [9:0] ys;
    sum_t l;
    sum_t us;
    sum_t vs;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    ys = $signed({2'b00, y}) - LumaOffs;
    l  = CoefY * sum_t'(ys);
    if (l < 0) begin
      l = '0;
    end
    us = sum_t'(u);
    vs = sum_t'(v);
    r  = chan_clamp(l + CoefRv * vs);
    g  = chan_clamp(l - CoefGv * vs - CoefGu * us);
    b  = chan_clamp(l + CoefBu * us);
    return {AlphaVal, b, g, r};
  endfunction

endpackage

`default_nettype wire

### design/yuyv_to_abgr_convert_top.sv
// ----------------------------------------------------------------------------
// yuyv_to_abgr_convert_top
// Converts one YUYV macropixel per beat into two packed ABGR pixels that
// share the chroma; the frame-end flag travels alongside.
// ----------------------------------------------------------------------------
// Registers: input reg, then result reg. Throughput: one beat per cycle while
// out_ready_i does not stall the output; the only arithmetic stage is the
// constant multiply, add and clamp between the input and result registers.
// Reset: asynchronous, active low; clears both valid flags, payload is kept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module yuyv_to_abgr_convert_top
  import y2abgr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  luma_first_i,
  input  wire logic [7:0]  chroma_blue_i,
  input  wire logic [7:0]  luma_second_i,
  input  wire logic [7:0]  chroma_red_i,
  input  wire logic        frame_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      pixel_first_o,
  output logic [31:0]      pixel_second_o,
  output logic             frame_end_out_o
);

  logic        in_vld_q;
  logic [7:0]  y0_q;
  logic [7:0]  cb_q;
  logic [7:0]  y1_q;
  logic [7:0]  cr_q;
  logic        fe_q;
  logic        out_vld_q;
  logic [31:0] px0_q, px0_d;
  logic [31:0] px1_q, px1_d;
  logic        fe_out_q;
  logic        adv;
  logic        take;
  logic signed [8:0] u_s;
  logic signed [8:0] v_s;

  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || adv;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      y0_q <= luma_first_i;
      cb_q <= chroma_blue_i;
      y1_q <= luma_second_i;
      cr_q <= chroma_red_i;
      fe_q <= frame_end_i;
    end
  end

  always_comb begin
    u_s   = $signed({1'b0, cb_q}) - ChrOffs;
    v_s   = $signed({1'b0, cr_q}) - ChrOffs;
    px0_d = make_pixel(y0_q, u_s, v_s);
    px1_d = make_pixel(y1_q, u_s, v_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_vld_q) begin
      px0_q    <= px0_d;
      px1_q    <= px1_d;
      fe_out_q <= fe_q;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign pixel_first_o   = px0_q;
  assign pixel_second_o  = px1_q;
  assign frame_end_out_o = fe_out_q;

  // result always carries opaque alpha
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixel_first_o[31:24] == AlphaVal && pixel_second_o[31:24] == AlphaVal))
    else $error("alpha byte not opaque");

  // input stalls only when both stages are full and output is blocked
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled with free stage");

  // an accepted beat shows up in the input register next cycle
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> in_vld_q)
    else $error("accepted beat lost");

endmodule

`default_nettype wire
